@@ sv/smnl_pkg.sv @@
// Package with the shared constants and codes of the sparse map nearest lookup block.
package smnl_pkg;

	localparam int TABLE_DEPTH = 512;
	localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = ADDR_W + 1;

	localparam int KIND_W = 2;
	localparam int INDEX_W = 10;
	localparam int VALUE_W = 32;
	localparam int FOUND_INDEX_W = 9;

	localparam int APB_DW = 32;
	localparam int PADDR_W = 3;
	localparam int MODE_W = 2;

	localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SET = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

	localparam logic [MODE_W-1:0] MODE_BLOCK = 2'd0;
	localparam logic [MODE_W-1:0] MODE_NEAREST = 2'd1;
	localparam logic [MODE_W-1:0] MODE_UP_WRAP = 2'd2;
	localparam logic [MODE_W-1:0] MODE_DOWN_WRAP = 2'd3;

	localparam logic [PADDR_W-3:0] REG_ABSENT_MODE = '0;

endpackage

@@ sv/smnl_if.sv @@
// Request and response channel interfaces of the sparse map nearest lookup block.
interface smnl_req_if;
	import smnl_pkg::*;

	logic valid;
	logic ready;
	logic [KIND_W-1:0] kind;
	logic signed [INDEX_W-1:0] index;
	logic signed [VALUE_W-1:0] entry_value;

	modport source (output valid, output kind, output index, output entry_value, input ready);
	modport sink (input valid, input kind, input index, input entry_value, output ready);
endinterface

interface smnl_rsp_if;
	import smnl_pkg::*;

	logic valid;
	logic ready;
	logic signed [VALUE_W-1:0] found_value;
	logic [FOUND_INDEX_W-1:0] found_index;
	logic exact_hit;

	modport source (output valid, output found_value, output found_index, output exact_hit,
		input ready);
	modport sink (input valid, input found_value, input found_index, input exact_hit,
		output ready);
endinterface

@@ sv/smnl_ram.sv @@
// Single-port synchronous RAM with a registered read port.
module smnl_ram #(
	parameter int DEPTH = 512,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

@@ sv/smnl_regs.sv @@
// APB configuration register file holding the absent mode.
module smnl_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [smnl_pkg::PADDR_W-1:0]    paddr,
	input  logic [smnl_pkg::APB_DW-1:0]     pwdata,
	output logic [smnl_pkg::APB_DW-1:0]     prdata,
	output logic [smnl_pkg::MODE_W-1:0]     absent_mode
);
	import smnl_pkg::*;

	logic [MODE_W-1:0] absent_mode_q;
	logic [PADDR_W-3:0] reg_idx;

	assign reg_idx = paddr[PADDR_W-1:2];
	assign absent_mode = absent_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			absent_mode_q <= MODE_BLOCK;
		end else if (psel && penable && pwrite && reg_idx == REG_ABSENT_MODE) begin
			absent_mode_q <= pwdata[MODE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_ABSENT_MODE) begin
			prdata = {{(APB_DW-MODE_W){1'b0}}, absent_mode_q};
		end
	end
endmodule

@@ sv/smnl_ctrl.sv @@
// Sequencer that clears, writes and searches the value table one entry per cycle.
module smnl_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [smnl_pkg::MODE_W-1:0]  absent_mode,
	smnl_req_if.sink                     req,
	smnl_rsp_if.source                   rsp
);
	import smnl_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_NEAR,
		ST_WRAP,
		ST_EMIT
	} state_t;

	localparam logic [ADDR_W-1:0] LAST = ADDR_W'(TABLE_DEPTH - 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

	state_t state_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic [ADDR_W-1:0] pos_q;
	logic [ADDR_W-1:0] highest_q;
	logic [CNT_W-1:0] d_q;
	logic side_dn_q;
	logic dir_down_q;
	logic [ADDR_W-1:0] cur_q;
	logic [CNT_W-1:0] cnt_q;
	logic pend_s1;
	logic [ADDR_W-1:0] pend_addr_s1;
	logic [VALUE_W-1:0] res_value_q;
	logic [ADDR_W-1:0] res_index_q;
	logic res_exact_q;
	logic out_valid_q;
	logic [VALUE_W-1:0] out_value_q;
	logic [FOUND_INDEX_W-1:0] out_index_q;
	logic out_exact_q;

	logic [FOUND_INDEX_W-1:0] req_pos;
	logic req_in_range;
	logic [ADDR_W-1:0] req_addr;

	logic mem_we;
	logic [ADDR_W-1:0] mem_addr;
	logic [VALUE_W-1:0] mem_wdata;
	logic [VALUE_W-1:0] mem_rdata;
	logic found;

	logic [CNT_W-1:0] up_sum;
	logic up_ok;
	logic dn_ok;
	logic near_done;
	logic near_issue;
	logic [ADDR_W-1:0] near_addr;
	logic [CNT_W-1:0] near_d_nx;
	logic near_side_nx;

	logic wrap_done;
	logic [ADDR_W-1:0] wrap_addr;

	assign req_pos = req.index[FOUND_INDEX_W-1:0];
	assign req_in_range = !req.index[INDEX_W-1] && (int'(req_pos) < TABLE_DEPTH);
	assign req_addr = ADDR_W'(req_pos);
	assign req.ready = (state_q == ST_IDLE);

	assign rsp.valid = out_valid_q;
	assign rsp.found_value = out_value_q;
	assign rsp.found_index = out_index_q;
	assign rsp.exact_hit = out_exact_q;

	assign found = pend_s1 && (mem_rdata != '0);

	assign up_sum = {1'b0, pos_q} + d_q;
	assign up_ok = up_sum < DEPTH_C;
	assign dn_ok = d_q <= {1'b0, pos_q};
	assign near_done = !up_ok && !dn_ok;

	always_comb begin
		near_issue = 1'b0;
		near_addr = pos_q - d_q[ADDR_W-1:0];
		near_d_nx = d_q + 1'b1;
		near_side_nx = 1'b0;
		if (!side_dn_q && up_ok) begin
			near_issue = 1'b1;
			near_addr = up_sum[ADDR_W-1:0];
			near_d_nx = d_q;
			near_side_nx = 1'b1;
		end else if (dn_ok) begin
			near_issue = 1'b1;
		end
	end

	assign wrap_done = (cnt_q == DEPTH_C);

	always_comb begin
		if (dir_down_q) begin
			wrap_addr = (cur_q == '0) ? LAST : cur_q - 1'b1;
		end else begin
			wrap_addr = (cur_q == LAST) ? '0 : cur_q + 1'b1;
		end
	end

	always_comb begin
		mem_we = 1'b0;
		mem_addr = pos_q;
		mem_wdata = req.entry_value;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_addr = clr_addr_q;
				mem_wdata = '0;
			end
			ST_IDLE: begin
				mem_addr = req_addr;
				mem_we = req.valid && req.kind == KIND_SET && req_in_range;
			end
			ST_NEAR: mem_addr = near_addr;
			ST_WRAP: mem_addr = wrap_addr;
			default: mem_addr = pos_q;
		endcase
	end

	smnl_ram #(
		.DEPTH(TABLE_DEPTH),
		.WIDTH(VALUE_W)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_addr_q <= '0;
			highest_q <= '0;
			pend_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && rsp.ready && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req.valid) begin
						unique case (req.kind)
							KIND_LOOKUP: begin
								if (req_in_range) begin
									pos_q <= req_addr;
									state_q <= ST_LOOK;
								end
							end
							KIND_SET: begin
								if (req_in_range && req_addr > highest_q) begin
									highest_q <= req_addr;
								end
							end
							KIND_CLEAR: begin
								highest_q <= '0;
								state_q <= ST_CLEAR;
							end
							default: ;
						endcase
					end
				end
				ST_LOOK: begin
					pend_s1 <= 1'b0;
					d_q <= CNT_W'(1);
					side_dn_q <= 1'b0;
					cur_q <= pos_q;
					cnt_q <= CNT_W'(1);
					dir_down_q <= (absent_mode == MODE_DOWN_WRAP);
					if (mem_rdata != '0) begin
						res_value_q <= mem_rdata;
						res_index_q <= pos_q;
						res_exact_q <= 1'b1;
						state_q <= ST_EMIT;
					end else begin
						unique case (absent_mode)
							MODE_NEAREST: state_q <= ST_NEAR;
							MODE_UP_WRAP, MODE_DOWN_WRAP: begin
								state_q <= (highest_q != '0) ? ST_WRAP : ST_IDLE;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_NEAR: begin
					if (found) begin
						res_value_q <= mem_rdata;
						res_index_q <= pend_addr_s1;
						res_exact_q <= 1'b0;
						pend_s1 <= 1'b0;
						state_q <= ST_EMIT;
					end else if (near_done) begin
						pend_s1 <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						pend_s1 <= near_issue;
						pend_addr_s1 <= near_addr;
						d_q <= near_d_nx;
						side_dn_q <= near_side_nx;
					end
				end
				ST_WRAP: begin
					if (found) begin
						res_value_q <= mem_rdata;
						res_index_q <= pend_addr_s1;
						res_exact_q <= 1'b0;
						pend_s1 <= 1'b0;
						state_q <= ST_EMIT;
					end else if (wrap_done) begin
						pend_s1 <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						pend_s1 <= 1'b1;
						pend_addr_s1 <= wrap_addr;
						cur_q <= wrap_addr;
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						out_value_q <= res_value_q;
						out_index_q <= FOUND_INDEX_W'(res_index_q);
						out_exact_q <= res_exact_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

@@ sv/sparse_map_nearest_lookup_top.sv @@
// Top level of the sparse map nearest lookup block.
//
// Channel  Direction  Transfer moves
// req      sink       kind, index, entry_value
// rsp      source     found_value, found_index, exact_hit
// apb      slave      absent_mode register at byte address 0
//
// A set or an ignored item is handled in the idle state in which it is taken.
// A lookup reads the table in the look state; a miss without search ends there,
// and an exact hit passes through the emit state to reach the output register.
// A search reads the single table port at most once per cycle.
// After reset and after every clear, a clearing pass writes one entry per cycle
// through all 512 entries, during which req.ready stays low.
// A stalled result waits in the output register while the next item is taken.
module sparse_map_nearest_lookup_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [smnl_pkg::PADDR_W-1:0]  paddr,
	input  logic [smnl_pkg::APB_DW-1:0]   pwdata,
	output logic [smnl_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	smnl_req_if.sink                      req,
	smnl_rsp_if.source                    rsp
);
	import smnl_pkg::*;

	logic [MODE_W-1:0] absent_mode;

	assign pready = 1'b1;

	smnl_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.absent_mode(absent_mode)
	);

	smnl_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.absent_mode(absent_mode),
		.req        (req),
		.rsp        (rsp)
	);
endmodule

@@ sv/smnl_checker.sv @@
// Port-level checker for the sparse map nearest lookup block and its bind.
module smnl_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	input  logic                               req_ready,
	input  logic [smnl_pkg::KIND_W-1:0]        req_kind,
	input  logic signed [smnl_pkg::INDEX_W-1:0] req_index,
	input  logic                               rsp_valid,
	input  logic                               rsp_ready,
	input  logic signed [smnl_pkg::VALUE_W-1:0] rsp_found_value,
	input  logic [smnl_pkg::FOUND_INDEX_W-1:0] rsp_found_index,
	input  logic                               rsp_exact_hit
);
	import smnl_pkg::*;

	logic req_xfer;

	assign req_xfer = req_valid && req_ready;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found_value)
			&& $stable(rsp_found_index) && $stable(rsp_exact_hit))
		else $error("Stalled result changed or dropped.");

	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_xfer && req_kind == KIND_CLEAR |=> !req_ready)
		else $error("Request taken right after a clear transfer.");

	a_set_silent: assert property (@(posedge clk) disable iff (!arst_n)
		req_xfer && req_kind == KIND_SET && !rsp_valid |=> !rsp_valid)
		else $error("Set transfer produced a result.");

	a_neg_silent: assert property (@(posedge clk) disable iff (!arst_n)
		req_xfer && req_kind == KIND_LOOKUP && req_index[INDEX_W-1] && !rsp_valid
			|=> !rsp_valid ##1 !rsp_valid)
		else $error("Negative lookup produced a result.");
endmodule

bind sparse_map_nearest_lookup_top smnl_checker u_smnl_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.req_kind       (req.kind),
	.req_index      (req.index),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_found_value(rsp.found_value),
	.rsp_found_index(rsp.found_index),
	.rsp_exact_hit  (rsp.exact_hit)
);
